>>> rtl/utcde_pkg.sv
package utcde_pkg;

  // Days from 0000-01-01 in the proleptic count to 1970-01-01
  localparam int unsigned EpochDays = 719528;
  localparam int unsigned SecPerDay = 86400;
  // Reciprocal of 25 scaled by 2^RecipShift, exact for inputs below 4681
  localparam int unsigned Recip25    = 2622;
  localparam int unsigned RecipShift = 16;

  // Stage A result: year with month carry applied
  typedef struct packed {
    logic [14:0] year;
    logic        late;     // month is March or later
    logic [8:0]  doy;      // days of whole months before, plus day of month
    logic [16:0] tod;      // hour, minute and second in seconds
  } fa_t;

  // Front end result: reciprocal products ready for the leap count
  typedef struct packed {
    logic [14:0] year;
    logic        year_zero;
    logic [12:0] year4;    // year / 4
    logic [24:0] prod_y;   // year4 * Recip25
    logic [11:0] prev4;    // (year - 1) / 4
    logic [23:0] prod_p;   // prev4 * Recip25
    logic        late;
    logic [8:0]  doy;
    logic [16:0] tod;
  } fr_t;

  // Day count relative to the epoch
  typedef struct packed {
    logic signed [24:0] days;
    logic [16:0]        tod;
  } dy_t;

  // Days in all whole months before month mon (0 = January)
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/utc_date_to_epoch_seconds.sv
// Channel  Dir  Payload
// s_axis   in   calendar time: year, month, day, hour, minute, second
// m_axis   out  signed seconds since 1970-01-01 00:00:00 UTC
// cfg      in   leap day rule (1 = Gregorian, 0 = every fourth year)
//
// One transfer per cycle in and out while m_tready stays high; five register
// stages lie between the input transfer and the output transfer.
// The depth is set by the month carry, the two reciprocal multiplies for the
// century terms, the day sum, the days-to-seconds multiply and the time-of-day add.
// rst is synchronous and clears the stage valid bits; the rule resets to 1.
// A stall on m_axis holds each stage in place and backs up to s_tready.
module utc_date_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [13:0] calendar_year, [17:14] month_index, [22:18] day_of_month,
  // [27:23] hour_of_day, [33:28] minute_of_hour, [39:34] second_of_minute
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [38:0] epoch_seconds (signed), [39] zero
  output logic [39:0] m_tdata
);
  import utcde_pkg::*;

  logic        gregorian_leap_rule;
  logic        fr_valid;
  logic        fr_ready;
  fr_t         fr_data;
  logic        dy_valid;
  logic        dy_ready;
  dy_t         dy_data;
  logic [38:0] epoch_seconds;

  // Hold the leap rule register
  always_ff @(posedge clk) begin
    if (rst) begin
      gregorian_leap_rule <= 1'b1;
    end else if (cfg_wr_en) begin
      gregorian_leap_rule <= cfg_wr_data;
    end
  end

  utcde_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .calendar_year    (s_tdata[13:0]),
    .month_index      (s_tdata[17:14]),
    .day_of_month     (s_tdata[22:18]),
    .hour_of_day      (s_tdata[27:23]),
    .minute_of_hour   (s_tdata[33:28]),
    .second_of_minute (s_tdata[39:34]),
    .out_valid        (fr_valid),
    .out_ready        (fr_ready),
    .out_data         (fr_data)
  );

  utcde_days u_days (
    .clk                 (clk),
    .rst                 (rst),
    .gregorian_leap_rule (gregorian_leap_rule),
    .in_valid            (fr_valid),
    .in_ready            (fr_ready),
    .in_data             (fr_data),
    .out_valid           (dy_valid),
    .out_ready           (dy_ready),
    .out_data            (dy_data)
  );

  utcde_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dy_valid),
    .in_ready  (dy_ready),
    .in_data   (dy_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_secs  (epoch_seconds)
  );

  assign m_tdata = {1'b0, epoch_seconds};

endmodule

>>> rtl/utcde_front.sv
module utcde_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        calendar_year,
  input  logic [3:0]         month_index,
  input  logic [4:0]         day_of_month,
  input  logic [4:0]         hour_of_day,
  input  logic [5:0]         minute_of_hour,
  input  logic [5:0]         second_of_minute,
  output logic               out_valid,
  input  logic               out_ready,
  output utcde_pkg::fr_t     out_data
);
  import utcde_pkg::*;

  logic       a_valid;
  fa_t        a_data;
  fa_t        a_next;
  logic       a_ready;
  logic       b_ready;
  fr_t        b_next;
  logic       carry;
  logic [3:0] mon;
  logic [14:0] prev;

  // Stage A: month carry, month table, time of day
  always_comb begin
    carry = (month_index >= 4'd12);
    mon   = carry ? (month_index - 4'd12) : month_index;
    a_next.year = {1'b0, calendar_year} + {14'd0, carry};
    a_next.late = (mon >= 4'd2);
    a_next.doy  = cum_days(mon) + {4'd0, day_of_month};
    a_next.tod  = (17'(hour_of_day) * 17'd3600) + (17'(minute_of_hour) * 17'd60)
                + {11'd0, second_of_minute};
  end

  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_data <= a_next;
    end
  end

  // Stage B: quarter years and reciprocal products for division by 100
  always_comb begin
    prev            = a_data.year - 15'd1;
    b_next.year     = a_data.year;
    b_next.year_zero = (a_data.year == 15'd0);
    b_next.year4    = a_data.year[14:2];
    b_next.prod_y   = 25'(a_data.year[14:2]) * 25'(Recip25);
    b_next.prev4    = prev[13:2];
    b_next.prod_p   = 24'(prev[13:2]) * 24'(Recip25);
    b_next.late     = a_data.late;
    b_next.doy      = a_data.doy;
    b_next.tod      = a_data.tod;
  end

  assign b_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

>>> rtl/utcde_days.sv
module utcde_days (
  input  logic               clk,
  input  logic               rst,
  input  logic               gregorian_leap_rule,
  input  logic               in_valid,
  output logic               in_ready,
  input  utcde_pkg::fr_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output utcde_pkg::dy_t     out_data
);
  import utcde_pkg::*;

  logic [7:0]         q100_p;
  logic [7:0]         q100_y;
  logic signed [13:0] leaps;
  logic               cent;
  logic               leap;
  logic [9:0]         doy;
  logic [23:0]        base;
  dy_t                c_next;

  // Leap count before the year, leap day within it, day number
  always_comb begin
    q100_p = in_data.prod_p[RecipShift +: 8];
    q100_y = in_data.prod_y[RecipShift +: 8];
    if (in_data.year_zero) begin
      leaps = -14'sd1;
    end else begin
      leaps = $signed({2'b00, in_data.prev4}) - $signed({6'd0, q100_p})
            + $signed({8'd0, q100_p[7:2]});
    end
    cent = (in_data.year4 == (13'(q100_y) * 13'd25));
    leap = (in_data.year[1:0] == 2'd0)
        && (!gregorian_leap_rule || !cent || (q100_y[1:0] == 2'd0));
    doy  = {1'b0, in_data.doy} + {9'd0, in_data.late && leap};
    base = 24'(in_data.year) * 24'd365;
    c_next.days = $signed({1'b0, base}) + 25'(leaps) + $signed({15'd0, doy})
                - $signed(25'(EpochDays));
    c_next.tod  = in_data.tod;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= c_next;
    end
  end

endmodule

>>> rtl/utcde_scale.sv
module utcde_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  utcde_pkg::dy_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [38:0]        out_secs
);
  import utcde_pkg::*;

  localparam logic signed [17:0] DaySecs = 18'(SecPerDay);

  logic               d_valid;
  logic               d_ready;
  logic               e_ready;
  logic signed [39:0] d_prod;
  logic [16:0]        d_tod;
  logic signed [39:0] prod_next;

  // Stage D: days to seconds
  assign prod_next = 40'($signed(in_data.days)) * 40'(DaySecs);
  assign d_ready   = !d_valid || e_ready;
  assign in_ready  = d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && in_valid) begin
      d_prod <= prod_next;
      d_tod  <= in_data.tod;
    end
  end

  // Stage E: add time of day, wrap to 39 bits
  assign e_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_ready) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && d_valid) begin
      out_secs <= 39'(d_prod[38:0] + {22'd0, d_tod});
    end
  end

endmodule

>>> test/utc_epoch_checker.sv
module utc_epoch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [13:0] calendar_year, [17:14] month_index, [22:18] day_of_month,
  // [27:23] hour_of_day, [33:28] minute_of_hour, [39:34] second_of_minute
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [38:0] epoch_seconds (signed), [39] zero
  input  logic [39:0] m_tdata,
  output int          mismatches,
  output int          in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // Day number of 1970-01-01 in the proleptic count
  localparam longint EpochDayNum = 719528;

  logic                   rule_greg;
  logic signed [38:0]     epoch_q[$];

  function automatic longint month_len(input int m);
    case (m)
      1:       return 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // Floor division, so year zero counts minus one leap day before it
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && (a < 0)) q = q - 1;
    return q;
  endfunction

  // Seconds since the epoch for one calendar time, wrapped to 39 bits
  function automatic logic signed [38:0] epoch_of(input logic [39:0] t, input logic greg);
    longint year, mon, prev, leap_days, doy, day_num, secs;
    bit     is_leap;
    year      = longint'(t[13:0]) + longint'(t[17:14] / 4'd12);
    mon       = longint'(t[17:14] % 4'd12);
    prev      = year - 1;
    leap_days = floor_div(prev, 4) - floor_div(prev, 100) + floor_div(prev, 400);
    doy       = longint'(t[22:18]);
    for (int m = 0; m < mon; m++) doy = doy + month_len(m);
    is_leap = (year % 4) == 0;
    if (greg) is_leap = (is_leap && (year % 100 != 0)) || (year % 400 == 0);
    if (mon >= 2 && is_leap) doy = doy + 1;
    day_num = 365 * year + leap_days + doy - EpochDayNum;
    secs = ((day_num * 24 + longint'(t[27:23])) * 60 + longint'(t[33:28])) * 60
           + longint'(t[39:34]);
    return secs[38:0];
  endfunction

  // Track the rule, queue predictions on input transfers, check output transfers
  always @(posedge clk) begin : watch
    logic signed [38:0] want;
    int                 bad;
    bad = 0;
    if (rst) begin
      rule_greg <= 1'b1;
      epoch_q.delete();
      in_flight <= 0;
    end else begin
      if (cfg_wr_en) rule_greg <= cfg_wr_data;
      if (s_tvalid && s_tready) epoch_q.push_back(epoch_of(s_tdata, rule_greg));
      if (m_tvalid && m_tready) begin
        if (epoch_q.size() == 0) begin
          $error("epoch_seconds: got %0d with no conversion pending",
                 $signed(m_tdata[38:0]));
          bad++;
        end else begin
          want = epoch_q.pop_front();
          if (m_tdata[38:0] !== want) begin
            $error("epoch_seconds: expected %0d, actual %0d", want,
                   $signed(m_tdata[38:0]));
            bad++;
          end
          if (m_tdata[39] !== 1'b0) begin
            $error("pad bit 39: expected 0, actual %b", m_tdata[39]);
            bad++;
          end
        end
      end
      in_flight <= epoch_q.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

>>> test/tb_utc_date_to_epoch_seconds.sv
module tb_utc_date_to_epoch_seconds;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdlePct     = 27;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 12;
  localparam int PhaseItems  = 163;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid    = 1'b0;
  logic [39:0] s_tdata     = '0;
  logic        m_tready    = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  int          mismatches;
  int          in_flight;
  bit          steady      = 1'b0;
  int          sent        = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  utc_date_to_epoch_seconds u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  utc_epoch_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .in_flight   (in_flight)
  );

  // Stall the output at random, except during the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb_utc_date_to_epoch_seconds: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [39:0] pack_time(input int yr, input int mi, input int day,
                                            input int hr, input int mn, input int sc);
    return {sc[5:0], mn[5:0], hr[4:0], day[4:0], mi[3:0], yr[13:0]};
  endfunction

  // Mostly plain dates, a share near century boundaries, the rest raw bits
  function automatic logic [39:0] random_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      return pack_time($urandom_range(1, 9999), $urandom_range(0, 11), $urandom_range(1, 31),
                       $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 60));
    if (pick < 75)
      return pack_time(100 * $urandom_range(1, 99) + $urandom_range(0, 4) - 1,
                       $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 63), $urandom_range(0, 63));
    return {8'($urandom_range(255)), $urandom()};
  endfunction

  // Present one item, idling first at random, and hold until the transfer
  task automatic send_time(input logic [39:0] item);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Hold off the input until every pending result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_rule(input logic greg);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= greg;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Gregorian rule from reset: extremes, year zero, carries, oversized fields
    send_time(pack_time(1970, 0, 1, 0, 0, 0));
    send_time(pack_time(1, 0, 1, 0, 0, 0));
    send_time(pack_time(9999, 11, 31, 23, 59, 59));
    send_time(pack_time(0, 0, 1, 0, 0, 0));
    send_time(pack_time(0, 2, 1, 0, 0, 0));
    send_time(pack_time(16383, 15, 31, 31, 63, 63));
    send_time(pack_time(0, 0, 0, 0, 0, 0));
    send_time(pack_time(2000, 2, 1, 0, 0, 0));
    send_time(pack_time(1900, 2, 1, 0, 0, 0));
    send_time(pack_time(2100, 2, 1, 0, 0, 0));
    send_time(pack_time(2024, 1, 29, 12, 0, 0));
    send_time(pack_time(2024, 12, 1, 0, 0, 0));
    send_time(pack_time(1999, 13, 28, 6, 30, 15));
    send_time(pack_time(2038, 0, 19, 3, 14, 8));
    send_time(pack_time(2016, 11, 31, 23, 59, 60));
    send_time(pack_time(2023, 5, 0, 0, 0, 0));
    send_time(pack_time(1970, 0, 1, 31, 63, 63));

    // Every-fourth-year rule on century years
    write_rule(1'b0);
    send_time(pack_time(1900, 2, 1, 0, 0, 0));
    send_time(pack_time(2100, 5, 15, 8, 0, 0));
    send_time(pack_time(2000, 2, 1, 0, 0, 0));
    send_time(pack_time(1800, 11, 31, 23, 59, 59));
    send_time(pack_time(0, 2, 1, 0, 0, 0));
    send_time(pack_time(400, 14, 1, 0, 0, 0));

    // Random phases with alternating rule; phase two runs without idling
    for (int phase = 0; phase < 4; phase++) begin
      write_rule(phase % 2 == 0);
      steady <= (phase == 2);
      for (int i = 0; i < PhaseItems; i++) begin
        if (phase == 1 && i == PhaseItems / 2) drain();
        send_time(random_time());
      end
    end
    steady <= 1'b0;

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Converted %0d calendar times: both leap rules, years 0 to 16383,", sent);
    $display("month carry, day zero and oversized time fields, random stalls on both sides.");
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_utc_date_to_epoch_seconds: clean");
    end else begin
      $display("tb_utc_date_to_epoch_seconds: errors");
    end
    $finish;
  end

endmodule
